@@ hdl/point_in_convex_polygon_test_unit_macros.svh @@
`ifndef POINT_IN_CONVEX_POLYGON_TEST_UNIT_MACROS_SVH
`define POINT_IN_CONVEX_POLYGON_TEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PICP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PICP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/picp_pkg.sv @@
`default_nettype none

package picp_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 32;
    localparam int COORD_W          = 32;
    localparam int CMD_W            = 2;
    localparam int STAT_W           = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TWO = 2'd2;

    typedef enum logic [1:0] {
        SGN_NEG,
        SGN_ZERO,
        SGN_POS
    } sgn_t;

    typedef enum logic [1:0] {
        XP_IDLE,
        XP_MULP,
        XP_MULQ,
        XP_CMP
    } xph_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_RD_I,
        ST_RD_J,
        ST_START,
        ST_WAIT,
        ST_REPORT
    } state_t;

    typedef enum logic [2:0] {
        OP_SEARCH,
        OP_END,
        OP_LEFT,
        OP_MID,
        OP_RIGHT
    } op_t;

    typedef struct packed {
        logic done;
        sgn_t sign;
    } xres_t;

endpackage

`default_nettype wire

@@ hdl/picp_cross.sv @@
`default_nettype none

module picp_cross #(
    parameter int COORD_BITS = picp_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [COORD_BITS-1:0] ix,
    input  wire logic signed [COORD_BITS-1:0] iy,
    input  wire logic signed [COORD_BITS-1:0] jx,
    input  wire logic signed [COORD_BITS-1:0] jy,
    input  wire logic signed [COORD_BITS-1:0] kx,
    input  wire logic signed [COORD_BITS-1:0] ky,
    output picp_pkg::xres_t                   res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    picp_pkg::xph_t phase_reg, phase_next;

    logic signed [DW-1:0] ujx_reg, ujy_reg, ukx_reg, uky_reg;
    logic signed [PW-1:0] p_reg, q_reg;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            picp_pkg::XP_IDLE: if (start) phase_next = picp_pkg::XP_MULP;
            picp_pkg::XP_MULP: phase_next = picp_pkg::XP_MULQ;
            picp_pkg::XP_MULQ: phase_next = picp_pkg::XP_CMP;
            picp_pkg::XP_CMP:  phase_next = picp_pkg::XP_IDLE;
            default:           phase_next = picp_pkg::XP_IDLE;
        endcase
    end

    // One multiplier, used for both products of the cross term
    always_comb
    begin
        mul_a = ujx_reg;
        mul_b = uky_reg;
        res.done = 1'b0;
        res.sign = picp_pkg::SGN_ZERO;
        unique case (phase_reg)
            picp_pkg::XP_MULQ:
            begin
                mul_a = ujy_reg;
                mul_b = ukx_reg;
            end
            picp_pkg::XP_CMP:
            begin
                res.done = 1'b1;
                if (p_reg > q_reg)
                    res.sign = picp_pkg::SGN_POS;
                else if (p_reg == q_reg)
                    res.sign = picp_pkg::SGN_ZERO;
                else
                    res.sign = picp_pkg::SGN_NEG;
            end
            default:
            begin
                mul_a = ujx_reg;
                mul_b = uky_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= picp_pkg::XP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == picp_pkg::XP_IDLE && start)
        begin
            ujx_reg <= {jx[COORD_BITS-1], jx} - {ix[COORD_BITS-1], ix};
            ujy_reg <= {jy[COORD_BITS-1], jy} - {iy[COORD_BITS-1], iy};
            ukx_reg <= {kx[COORD_BITS-1], kx} - {ix[COORD_BITS-1], ix};
            uky_reg <= {ky[COORD_BITS-1], ky} - {iy[COORD_BITS-1], iy};
        end
        if (phase_reg == picp_pkg::XP_MULP)
            p_reg <= prod;
        if (phase_reg == picp_pkg::XP_MULQ)
            q_reg <= prod;
    end

endmodule

`default_nettype wire

@@ hdl/point_in_convex_polygon_test_unit.sv @@
// Point-in-convex-polygon tester. Vertices are appended one per transaction
// (cmd append) into an on-chip table of MAX_VERTICES entries and are meant to
// be given in counterclockwise order; cmd clear empties the table and clears
// the overflow flag. A query transaction returns one result: inside_res and
// status (ok, table overflowed earlier, or two-vertex polygon which always
// answers outside). Only the low COORD_BITS bits of px and py are used, as
// two's complement. Queries on fewer than three vertices answer in the cycle
// after they are accepted. Larger queries run a binary search over the fan
// around vertex 0, then three or four triangle tests; each cross product is
// formed by the single shared multiplier (two products in turn) from vertices
// read through the one-read vertex table port. No new transaction is taken
// while a query runs. There is no clearing pass after reset.
`default_nettype none

module point_in_convex_polygon_test_unit #(
    parameter int MAX_VERTICES = picp_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = picp_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [picp_pkg::CMD_W-1:0]    cmd,
    input  wire logic signed [picp_pkg::COORD_W-1:0] px,
    input  wire logic signed [picp_pkg::COORD_W-1:0] py,
    input  wire logic                          include_edges,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               inside_res,
    output logic [picp_pkg::STAT_W-1:0]        status
);

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int AW1 = AW + 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    picp_pkg::state_t state_reg, state_next;
    picp_pkg::op_t    op_reg, op_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] l_reg, l_next, r_reg, r_next;
    logic [AW-1:0] ci_reg, ci_next, cj_reg, cj_next;
    logic          ok_reg, ok_next;
    logic          inc_reg, inc_next;
    logic [picp_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic          out_valid_reg, out_valid_next;
    logic          inside_reg, inside_next;
    logic [picp_pkg::STAT_W-1:0] status_reg, status_next;

    logic signed [CB-1:0] kx_reg, kx_next, ky_reg, ky_next;
    logic signed [CB-1:0] v0x_reg, v0x_next, v0y_reg, v0y_next;
    logic signed [CB-1:0] ai_x_reg, ai_x_next, ai_y_reg, ai_y_next;

    logic signed [CB-1:0] mem_x [MAX_VERTICES];
    logic signed [CB-1:0] mem_y [MAX_VERTICES];
    logic signed [CB-1:0] rd_x_reg, rd_y_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_raddr;

    logic signed [CB-1:0] kx_in, ky_in;
    logic                 acc;
    logic [CW-1:0]        n_m1, n_m2;
    logic [AW-1:0]        last_idx, pen_idx, m_idx, l_inc;
    logic [AW:0]          msum;
    logic                 l_is_first, l_is_pen, l_lt_r, plan_go;
    logic                 xstart;
    logic                 s_neg, s_zero, s_pos, fail;
    logic [picp_pkg::STAT_W-1:0] q_stat;
    picp_pkg::xres_t      xres;

    assign kx_in = px[CB-1:0];
    assign ky_in = py[CB-1:0];

    assign in_ready   = (state_reg == picp_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign acc        = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign status     = status_reg;

    assign n_m1       = count_reg - CW'(1);
    assign n_m2       = count_reg - CW'(2);
    assign last_idx   = n_m1[AW-1:0];
    assign pen_idx    = n_m2[AW-1:0];
    assign msum       = {1'b0, l_reg} + {1'b0, r_reg} + AW1'(1);
    assign m_idx      = msum[AW:1];
    assign l_inc      = l_reg + AW'(1);
    assign l_is_first = (l_reg == AW'(1));
    assign l_is_pen   = (l_reg == pen_idx);
    assign l_lt_r     = (l_reg < r_reg);

    assign s_neg  = (xres.sign == picp_pkg::SGN_NEG);
    assign s_zero = (xres.sign == picp_pkg::SGN_ZERO);
    assign s_pos  = (xres.sign == picp_pkg::SGN_POS);

    assign q_stat = (count_reg == CW'(2)) ? picp_pkg::STAT_TWO :
                    (ovf_reg ? picp_pkg::STAT_OVF : picp_pkg::STAT_OK);

    // Does the current step need a cross product, or is it skipped
    always_comb
    begin
        case (op_reg)
            picp_pkg::OP_SEARCH: plan_go = l_lt_r;
            picp_pkg::OP_END:    plan_go = l_is_first || l_is_pen;
            default:             plan_go = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            picp_pkg::ST_IDLE:
                if (acc && cmd == picp_pkg::CMD_QUERY && count_reg >= CW'(3))
                    state_next = picp_pkg::ST_PLAN;
            picp_pkg::ST_PLAN:
                if (plan_go)
                    state_next = picp_pkg::ST_RD_I;
            picp_pkg::ST_RD_I:  state_next = picp_pkg::ST_RD_J;
            picp_pkg::ST_RD_J:  state_next = picp_pkg::ST_START;
            picp_pkg::ST_START: state_next = picp_pkg::ST_WAIT;
            picp_pkg::ST_WAIT:
                if (xres.done)
                    state_next = (op_reg == picp_pkg::OP_RIGHT) ? picp_pkg::ST_REPORT
                                                                : picp_pkg::ST_PLAN;
            picp_pkg::ST_REPORT:
                if (!out_valid_reg || out_ready)
                    state_next = picp_pkg::ST_IDLE;
            default: state_next = picp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        ok_next        = ok_reg;
        inc_next       = inc_reg;
        stat_next      = stat_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        v0x_next       = v0x_reg;
        v0y_next       = v0y_reg;
        ai_x_next      = ai_x_reg;
        ai_y_next      = ai_y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        inside_next    = inside_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_raddr      = (state_reg == picp_pkg::ST_RD_I) ? ci_reg : cj_reg;
        xstart         = 1'b0;
        fail           = 1'b0;

        unique case (state_reg)
            picp_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd)
                        picp_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CW'(MAX_VERTICES))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    v0x_next = kx_in;
                                    v0y_next = ky_in;
                                end
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        picp_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        picp_pkg::CMD_QUERY:
                        begin
                            kx_next   = kx_in;
                            ky_next   = ky_in;
                            inc_next  = include_edges;
                            stat_next = q_stat;
                            if (count_reg < CW'(3))
                            begin
                                // answer small tables right away
                                out_valid_next = 1'b1;
                                status_next    = q_stat;
                                inside_next    = (count_reg == CW'(1)) && include_edges &&
                                                 (v0x_reg == kx_in) && (v0y_reg == ky_in);
                            end
                            else
                            begin
                                l_next  = AW'(1);
                                r_next  = pen_idx;
                                ok_next = 1'b1;
                                op_next = picp_pkg::OP_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            picp_pkg::ST_PLAN:
            begin
                case (op_reg)
                    picp_pkg::OP_SEARCH:
                    begin
                        ci_next = '0;
                        cj_next = m_idx;
                        if (!l_lt_r)
                            op_next = picp_pkg::OP_END;
                    end
                    picp_pkg::OP_END:
                    begin
                        ci_next = '0;
                        cj_next = l_is_first ? AW'(1) : last_idx;
                        if (!plan_go)
                            op_next = picp_pkg::OP_LEFT;
                    end
                    picp_pkg::OP_LEFT:
                    begin
                        ci_next = '0;
                        cj_next = l_reg;
                    end
                    picp_pkg::OP_MID:
                    begin
                        ci_next = l_reg;
                        cj_next = l_inc;
                    end
                    default:
                    begin
                        ci_next = l_inc;
                        cj_next = '0;
                    end
                endcase
            end
            picp_pkg::ST_RD_J:
            begin
                ai_x_next = rd_x_reg;
                ai_y_next = rd_y_reg;
            end
            picp_pkg::ST_START:
            begin
                xstart = 1'b1;
            end
            picp_pkg::ST_WAIT:
            begin
                if (xres.done)
                begin
                    case (op_reg)
                        picp_pkg::OP_SEARCH:
                        begin
                            if (!s_neg)
                                l_next = cj_reg;
                            else
                                r_next = cj_reg - AW'(1);
                        end
                        picp_pkg::OP_END:
                        begin
                            if (l_is_first)
                                fail = inc_reg ? s_neg : (s_neg || s_zero);
                            else
                                fail = inc_reg ? s_pos : (s_pos || s_zero);
                            op_next = picp_pkg::OP_LEFT;
                        end
                        picp_pkg::OP_LEFT:
                        begin
                            fail    = s_neg;
                            op_next = picp_pkg::OP_MID;
                        end
                        picp_pkg::OP_MID:
                        begin
                            fail    = inc_reg ? s_neg : (s_neg || s_zero);
                            op_next = picp_pkg::OP_RIGHT;
                        end
                        default:
                        begin
                            fail = s_neg;
                        end
                    endcase
                    ok_next = ok_reg && !fail;
                end
            end
            picp_pkg::ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = ok_reg;
                    status_next    = stat_reg;
                end
            end
            default: ;
        endcase
    end

    picp_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (xstart),
        .ix    (ai_x_reg),
        .iy    (ai_y_reg),
        .jx    (rd_x_reg),
        .jy    (rd_y_reg),
        .kx    (kx_reg),
        .ky    (ky_reg),
        .res   (xres)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[AW-1:0]] <= kx_in;
            mem_y[count_reg[AW-1:0]] <= ky_in;
        end
        rd_x_reg <= mem_x[mem_raddr];
        rd_y_reg <= mem_y[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= picp_pkg::ST_IDLE;
            op_reg        <= picp_pkg::OP_SEARCH;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        r_reg      <= r_next;
        ci_reg     <= ci_next;
        cj_reg     <= cj_next;
        ok_reg     <= ok_next;
        inc_reg    <= inc_next;
        stat_reg   <= stat_next;
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        v0x_reg    <= v0x_next;
        v0y_reg    <= v0y_next;
        ai_x_reg   <= ai_x_next;
        ai_y_reg   <= ai_y_next;
        inside_reg <= inside_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

@@ hdl/picp_checker.sv @@
`default_nettype none

`include "point_in_convex_polygon_test_unit_macros.svh"

module picp_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic [picp_pkg::CMD_W-1:0] cmd,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       inside_res,
    input wire logic [picp_pkg::STAT_W-1:0] status
);

    // hold a stalled result
    `PICP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(inside_res) && $stable(status), "result changed while stalled")

    // two-vertex polygons always answer outside
    `PICP_ASSERT_NOW(a_two_outside, out_valid && status == picp_pkg::STAT_TWO, !inside_res, "two-vertex polygon reported inside")

    // append, clear and unused commands never produce a result
    `PICP_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && cmd != picp_pkg::CMD_QUERY && !out_valid, !out_valid, "result without a query")

    // take no transaction while a result waits
    `PICP_ASSERT_NOW(a_ready_blocked, in_ready, !out_valid || out_ready, "input taken while a result is stalled")

endmodule

bind point_in_convex_polygon_test_unit picp_checker u_picp_checker (.*);

`default_nettype wire

@@ test/tb_point_in_convex_polygon_test_unit.sv @@
`timescale 1ns / 1ps

module tb_point_in_convex_polygon_test_unit;

    localparam int MAX_V = picp_pkg::MAX_VERTICES_DEF;
    localparam logic [picp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 70;

    typedef struct packed {
        logic [picp_pkg::CMD_W-1:0]   op;
        logic [picp_pkg::COORD_W-1:0] x;
        logic [picp_pkg::COORD_W-1:0] y;
        logic                         inc;
    } poly_txn_t;

    typedef struct packed {
        logic                        hit;
        logic [picp_pkg::STAT_W-1:0] status;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [picp_pkg::CMD_W-1:0] cmd = picp_pkg::CMD_APPEND;
    logic signed [picp_pkg::COORD_W-1:0] px = '0;
    logic signed [picp_pkg::COORD_W-1:0] py = '0;
    logic include_edges = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic inside_res;
    logic [picp_pkg::STAT_W-1:0] status;

    // vertex table as the block should hold it
    logic signed [picp_pkg::COORD_W-1:0] poly_x [MAX_V];
    logic signed [picp_pkg::COORD_W-1:0] poly_y [MAX_V];
    int unsigned poly_count = 0;
    bit poly_overflow = 1'b0;

    verdict_t expected_verdicts[$];
    poly_txn_t pending_txns[$];
    poly_txn_t next_txn;

    // vertices as issued, used only to aim query points
    longint shape_x[$];
    longint shape_y[$];

    int issued = 0;
    int mismatches = 0;
    int results_seen = 0;
    int cycle_cnt = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    wire calm = (cycle_cnt >= 4000) && (cycle_cnt < 7000);

    point_in_convex_polygon_test_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .px(px),
        .py(py),
        .include_edges(include_edges),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .inside_res(inside_res),
        .status(status)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sign of cross(b - a, q - a), exact at 128 bits
    function automatic picp_pkg::sgn_t turn_sign(int unsigned a, int unsigned b,
                                                 logic signed [picp_pkg::COORD_W-1:0] qx,
                                                 logic signed [picp_pkg::COORD_W-1:0] qy);
        logic signed [127:0] ex, ey, fx, fy, cr;
        ex = poly_x[b] - poly_x[a];
        ey = poly_y[b] - poly_y[a];
        fx = qx - poly_x[a];
        fy = qy - poly_y[a];
        cr = ex * fy - ey * fx;
        if (cr < 0)
            return picp_pkg::SGN_NEG;
        if (cr == 0)
            return picp_pkg::SGN_ZERO;
        return picp_pkg::SGN_POS;
    endfunction

    function automatic logic point_in_polygon(logic signed [picp_pkg::COORD_W-1:0] qx,
                                              logic signed [picp_pkg::COORD_W-1:0] qy,
                                              logic inc);
        int unsigned n, lo, hi, mid;
        picp_pkg::sgn_t c;
        logic ok;
        n = poly_count;
        ok = 1'b1;
        if (n == 0)
            return 1'b0;
        if (n == 1)
            return inc && poly_x[0] == qx && poly_y[0] == qy;
        if (n == 2)
            return 1'b0;
        // find the fan wedge around vertex 0
        lo = 1;
        hi = n - 2;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (turn_sign(0, mid, qx, qy) != picp_pkg::SGN_NEG)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo == 1)
        begin
            c = turn_sign(0, 1, qx, qy);
            if (inc ? (c == picp_pkg::SGN_NEG) : (c != picp_pkg::SGN_POS))
                ok = 1'b0;
        end
        else if (lo == n - 2)
        begin
            c = turn_sign(0, n - 1, qx, qy);
            if (inc ? (c == picp_pkg::SGN_POS) : (c != picp_pkg::SGN_NEG))
                ok = 1'b0;
        end
        if (turn_sign(0, lo, qx, qy) == picp_pkg::SGN_NEG)
            ok = 1'b0;
        c = turn_sign(lo, lo + 1, qx, qy);
        if (inc ? (c == picp_pkg::SGN_NEG) : (c != picp_pkg::SGN_POS))
            ok = 1'b0;
        if (turn_sign(lo + 1, 0, qx, qy) == picp_pkg::SGN_NEG)
            ok = 1'b0;
        return ok;
    endfunction

    task automatic track_transaction(logic [picp_pkg::CMD_W-1:0] op,
                                     logic signed [picp_pkg::COORD_W-1:0] x,
                                     logic signed [picp_pkg::COORD_W-1:0] y,
                                     logic inc);
        verdict_t v;
        case (op)
            picp_pkg::CMD_APPEND:
            begin
                if (poly_count < MAX_V)
                begin
                    poly_x[poly_count] = x;
                    poly_y[poly_count] = y;
                    poly_count++;
                end
                else
                begin
                    poly_overflow = 1'b1;
                end
            end
            picp_pkg::CMD_CLEAR:
            begin
                poly_count = 0;
                poly_overflow = 1'b0;
            end
            picp_pkg::CMD_QUERY:
            begin
                v.hit = point_in_polygon(x, y, inc);
                v.status = poly_overflow ? picp_pkg::STAT_OVF : picp_pkg::STAT_OK;
                if (poly_count == 2)
                    v.status = picp_pkg::STAT_TWO;
                expected_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(string what, verdict_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected hit=%0b status=%0d, got inside_res=%0b status=%0d",
                     $time, what, want.hit, want.status, inside_res, status);
    endtask

    task automatic push_item(logic [picp_pkg::CMD_W-1:0] op, longint x, longint y, bit inc);
        poly_txn_t t;
        t.op = op;
        t.x = x[picp_pkg::COORD_W-1:0];
        t.y = y[picp_pkg::COORD_W-1:0];
        t.inc = inc;
        pending_txns.push_back(t);
        if (op != CMD_UNUSED)
            issued++;
        if (op == picp_pkg::CMD_APPEND && shape_x.size() < MAX_V)
        begin
            shape_x.push_back(longint'(signed'(t.x)));
            shape_y.push_back(longint'(signed'(t.y)));
        end
        else if (op == picp_pkg::CMD_CLEAR)
        begin
            shape_x.delete();
            shape_y.delete();
        end
    endtask

    task automatic queue_query();
        longint qx, qy, lx, hx, ly, hy;
        int n, i, j, k, sel;
        n = shape_x.size();
        sel = (n == 0) ? 7 : $urandom_range(0, 8);
        j = (n == 0) ? 0 : $urandom_range(0, n - 1);
        k = (n == 0) ? 0 : (j + 1) % n;
        qx = longint'(int'($urandom()));
        qy = longint'(int'($urandom()));
        case (sel) inside
            0, 1:
            begin
                qx = shape_x[j];
                qy = shape_y[j];
            end
            2:
            begin
                qx = (shape_x[j] + shape_x[k]) >>> 1;
                qy = (shape_y[j] + shape_y[k]) >>> 1;
            end
            3:
            begin
                qx = shape_x[j] + int'($urandom_range(0, 2)) - 1;
                qy = shape_y[j] + int'($urandom_range(0, 2)) - 1;
            end
            4, 5:
            begin
                lx = shape_x[0];
                hx = shape_x[0];
                ly = shape_y[0];
                hy = shape_y[0];
                for (i = 1; i < n; i++)
                begin
                    if (shape_x[i] < lx) lx = shape_x[i];
                    if (shape_x[i] > hx) hx = shape_x[i];
                    if (shape_y[i] < ly) ly = shape_y[i];
                    if (shape_y[i] > hy) hy = shape_y[i];
                end
                qx = lx + longint'($urandom_range(0, 32'(hx - lx)));
                qy = ly + longint'($urandom_range(0, 32'(hy - ly)));
            end
            6:
            begin
                qx = (shape_x[0] + shape_x[j] + shape_x[k]) / 3;
                qy = (shape_y[0] + shape_y[j] + shape_y[k]) / 3;
            end
            8:
            begin
                qx = (shape_x[0] + shape_x[j]) >>> 1;
                qy = (shape_y[0] + shape_y[j]) >>> 1;
            end
            default: ;
        endcase
        if (qx > COORD_MAX) qx = COORD_MAX;
        if (qx < COORD_MIN) qx = COORD_MIN;
        if (qy > COORD_MAX) qy = COORD_MAX;
        if (qy < COORD_MIN) qy = COORD_MIN;
        push_item(picp_pkg::CMD_QUERY, qx, qy, $urandom_range(0, 1));
    endtask

    // convex polygon on a parabola, counterclockwise unless mirrored
    task automatic fill_convex(int n);
        longint sx, sy, span_x, span_y, x0, y0, x, y, t;
        int m, i, k, rot, orient, lim;
        bit tiny;
        m = (n > 1) ? n - 1 : 1;
        tiny = ($urandom_range(0, 3) == 0);
        lim = tiny ? 2 : 500000000 / (m * m);
        if (lim > 100000000) lim = 100000000;
        if (lim < 1) lim = 1;
        sy = 2 * longint'($urandom_range(1, lim));
        lim = tiny ? 2 : 500000000 / m;
        if (lim > 100000000) lim = 100000000;
        sx = 2 * longint'($urandom_range(1, lim));
        span_x = sx * m;
        span_y = sy * m * m;
        x0 = COORD_MIN + 1 + longint'($urandom_range(0, 32'(64'sd4294967294 - span_x)));
        y0 = COORD_MIN + 1 + longint'($urandom_range(0, 32'(64'sd4294967294 - span_y)));
        rot = $urandom_range(0, n - 1);
        orient = $urandom_range(0, 7);
        for (i = 0; i < n; i++)
        begin
            k = (i + rot) % n;
            x = x0 + longint'(k) * sx;
            y = y0 + longint'(k) * k * sy;
            case (orient) inside
                3, 4:
                begin
                    x = -x;
                    y = -y;
                end
                5, 6:
                begin
                    t = x;
                    x = -y;
                    y = t;
                end
                7: x = -x;
                default: ;
            endcase
            push_item(picp_pkg::CMD_APPEND, x, y, $urandom_range(0, 1));
        end
    endtask

    task automatic fill_scatter(int n);
        int i;
        bit wide;
        wide = $urandom_range(0, 1);
        for (i = 0; i < n; i++)
        begin
            if (wide)
                push_item(picp_pkg::CMD_APPEND, int'($urandom()), int'($urandom()),
                          $urandom_range(0, 1));
            else
                push_item(picp_pkg::CMD_APPEND, longint'($urandom_range(0, 40)) - 20,
                          longint'($urandom_range(0, 40)) - 20, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int sz;
        push_item(picp_pkg::CMD_QUERY, 0, 0, 1);
        push_item(picp_pkg::CMD_APPEND, 5, -7, 0);
        push_item(picp_pkg::CMD_QUERY, 5, -7, 1);
        push_item(picp_pkg::CMD_QUERY, 5, -7, 0);
        push_item(picp_pkg::CMD_QUERY, 6, -7, 1);
        push_item(picp_pkg::CMD_APPEND, 100, 100, 1);
        push_item(picp_pkg::CMD_QUERY, 50, 46, 1);
        push_item(CMD_UNUSED, COORD_MAX, COORD_MIN, 1);
        push_item(picp_pkg::CMD_CLEAR, -1, -1, 1);
        push_item(picp_pkg::CMD_APPEND, COORD_MIN, COORD_MIN, 0);
        push_item(picp_pkg::CMD_APPEND, COORD_MAX, COORD_MIN, 1);
        push_item(picp_pkg::CMD_APPEND, COORD_MAX, COORD_MAX, 0);
        push_item(picp_pkg::CMD_APPEND, COORD_MIN, COORD_MAX, 1);
        push_item(picp_pkg::CMD_QUERY, 0, 0, 0);
        push_item(picp_pkg::CMD_QUERY, COORD_MIN, COORD_MIN, 1);
        push_item(picp_pkg::CMD_QUERY, COORD_MIN, COORD_MIN, 0);
        push_item(picp_pkg::CMD_QUERY, COORD_MAX, 0, 1);
        push_item(picp_pkg::CMD_QUERY, COORD_MAX, 0, 0);
        push_item(picp_pkg::CMD_CLEAR, 0, 0, 0);
        // clockwise triangle
        push_item(picp_pkg::CMD_APPEND, 0, 0, 0);
        push_item(picp_pkg::CMD_APPEND, 0, 10, 0);
        push_item(picp_pkg::CMD_APPEND, 10, 0, 0);
        push_item(picp_pkg::CMD_QUERY, 1, 1, 1);

        while (issued < RANDOM_ITEMS)
        begin
            // now and then keep the old table so the new vertices pile on
            if ($urandom_range(0, 9) != 0)
                push_item(picp_pkg::CMD_CLEAR, int'($urandom()), int'($urandom()),
                          $urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: fill_scatter($urandom_range(0, 2));
                1: fill_scatter($urandom_range(3, 8));
                default:
                begin
                    sz = $urandom_range(0, 19);
                    if (sz < 16)
                        fill_convex($urandom_range(3, 24));
                    else if (sz < 19)
                        fill_convex($urandom_range(25, 60));
                    else
                        fill_convex($urandom_range(61, 90));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                push_item(CMD_UNUSED, int'($urandom()), int'($urandom()), $urandom_range(0, 1));
            repeat ($urandom_range(3, 12)) queue_query();
        end

        // full table, then overflow
        push_item(picp_pkg::CMD_CLEAR, 0, 0, 0);
        fill_convex(MAX_V);
        repeat (8) queue_query();
        repeat (3) push_item(picp_pkg::CMD_APPEND, int'($urandom()), int'($urandom()), 1);
        repeat (8) queue_query();
        push_item(picp_pkg::CMD_CLEAR, 0, 0, 1);
        queue_query();

        while (pending_txns.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // sender: hold the transaction until accepted, then maybe idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_transaction(cmd, px, py, include_edges);
            if (!in_valid || in_ready)
            begin
                if (pending_txns.size() != 0 && (calm || $urandom_range(99) >= 25))
                begin
                    next_txn = pending_txns.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_txn.op;
                    px <= next_txn.x;
                    py <= next_txn.y;
                    include_edges <= next_txn.inc;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check results, stall at random, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_verdicts.size() == 0)
                    note_mismatch("result with nothing pending", '0);
                else if (inside_res !== expected_verdicts[0].hit
                         || status !== expected_verdicts[0].status)
                    note_mismatch("result mismatch", expected_verdicts[0]);
                if (expected_verdicts.size() != 0)
                    void'(expected_verdicts.pop_front());
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 20)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
